/* design/cht_pkg.sv */
// chained hash table: shared types and codes
// no dependencies
package cht_pkg;
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [7:0] BUCKET_COUNT_RESET = 8'd100;
endpackage

/* design/chained_hash_table.sv */
// chained hash table top level: config register, front end, back end
// depends on cht_pkg, cht_front, cht_back
//
// channel  | handshake              | fields
// in_      | start & !busy          | in_action, in_key, in_payload
// out_     | out_valid (one cycle)  | out_status, out_found_payload, out_last
// cfg_     | psel&penable&pwrite    | pwdata[7:0] -> bucket_count (addr 0)
//
// from the accepting edge, the front end runs a bit-serial modulo over the key
// and then hands the request off to the back end
// the walker then reads the bucket head, visits the chain one entry at a time,
// and ends in a flush state for the final result of a lookup or of a delete that misses
// busy stays high until the walker is idle again, so one request is in flight
// reset is synchronous; after reset a clearing pass over every bucket wipes
// the bucket heads, with busy held high
// the receiver cannot stall results
module chained_hash_table import cht_pkg::*; #(
  parameter int MAX_BUCKETS = 128,
  parameter int POOL_ENTRIES = 64,
  parameter int KEY_BITS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_action,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [15:0]         in_payload,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [15:0]         out_found_payload,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int BW = $clog2(MAX_BUCKETS);
  logic [7:0] cfg_bucket_count_r;
  logic f_busy, q_valid, q_take, b_ready;
  logic [1:0] q_action;
  logic [KEY_BITS-1:0] q_key;
  logic [15:0] q_payload;
  logic [BW-1:0] q_bucket;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, cfg_bucket_count_r} : 32'd0;

  // bucket count register
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_bucket_count_r <= BUCKET_COUNT_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0)
      cfg_bucket_count_r <= pwdata[7:0];
  end

  // busy also covers the back end so a request only enters a free pipeline
  assign busy = f_busy | !b_ready;

  cht_front #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
    .clk, .rst_n, .req_valid(start && !busy), .req_action(in_action),
    .req_key(in_key), .req_payload(in_payload), .bucket_count(cfg_bucket_count_r),
    .busy(f_busy), .q_take, .q_valid, .q_action, .q_key, .q_payload, .q_bucket
  );

  cht_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES),
    .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_action, .q_key, .q_payload, .q_bucket, .q_take,
    .ready(b_ready), .res_valid(out_valid), .res_status(out_status),
    .res_payload(out_found_payload), .res_last(out_last)
  );
endmodule

/* design/cht_front.sv */
// chained hash table front end: request capture and key modulo
// depends on cht_pkg
module cht_front import cht_pkg::*; #(
  parameter int MAX_BUCKETS = 128,
  parameter int KEY_BITS = 40,
  localparam int BW = $clog2(MAX_BUCKETS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  logic [1:0]          req_action,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [15:0]         req_payload,
  input  logic [7:0]          bucket_count,
  output logic                busy,
  input  logic                q_take,
  output logic                q_valid,
  output logic [1:0]          q_action,
  output logic [KEY_BITS-1:0] q_key,
  output logic [15:0]         q_payload,
  output logic [BW-1:0]       q_bucket
);
  localparam int RW = KEY_BITS + 1;
  logic                act_r, act_nxt;
  logic [$clog2(KEY_BITS+1)-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt, sh_r, sh_nxt;
  logic [1:0]          action_r, action_nxt;
  logic [15:0]         pay_r, pay_nxt;
  logic [8:0]          mod_r, mod_nxt;
  logic                qv_r, qv_nxt;
  logic [RW-1:0]       trial;

  assign busy      = act_r | qv_r;
  assign q_valid   = qv_r;
  assign q_action  = action_r;
  assign q_key     = key_r;
  assign q_payload = pay_r;
  assign q_bucket  = rem_r[BW-1:0];

  // restoring remainder, one key bit per cycle
  always_comb begin
    act_nxt = act_r; cnt_nxt = cnt_r; rem_nxt = rem_r; key_nxt = key_r;
    sh_nxt = sh_r; action_nxt = action_r; pay_nxt = pay_r; mod_nxt = mod_r;
    qv_nxt = qv_r && !q_take;
    trial = {rem_r[RW-2:0], sh_r[KEY_BITS-1]};
    if (req_valid && !busy) begin
      act_nxt = 1'b1; cnt_nxt = '0; rem_nxt = '0;
      key_nxt = req_key; sh_nxt = req_key;
      action_nxt = req_action; pay_nxt = req_payload;
      if (bucket_count == 8'd0) mod_nxt = 9'd1;
      else if (32'(bucket_count) > MAX_BUCKETS) mod_nxt = 9'(MAX_BUCKETS);
      else mod_nxt = {1'b0, bucket_count};
    end else if (act_r) begin
      sh_nxt = sh_r << 1;
      rem_nxt = (trial >= RW'(mod_r)) ? trial - RW'(mod_r) : trial;
      cnt_nxt = cnt_r + 1'b1;
      if (32'(cnt_r) == KEY_BITS - 1) begin
        act_nxt = 1'b0; qv_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; qv_r <= 1'b0; cnt_r <= '0; mod_r <= 9'd1;
    end else begin
      act_r <= act_nxt; qv_r <= qv_nxt; cnt_r <= cnt_nxt; mod_r <= mod_nxt;
    end
    rem_r <= rem_nxt; key_r <= key_nxt; sh_r <= sh_nxt;
    action_r <= action_nxt; pay_r <= pay_nxt;
  end
endmodule

/* design/cht_back.sv */
// chained hash table back end: chain walker over head and entry memories
// depends on cht_pkg
module cht_back import cht_pkg::*; #(
  parameter int MAX_BUCKETS = 128,
  parameter int POOL_ENTRIES = 64,
  parameter int KEY_BITS = 40,
  localparam int BW = $clog2(MAX_BUCKETS),
  localparam int EW = $clog2(POOL_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  logic [1:0]          q_action,
  input  logic [KEY_BITS-1:0] q_key,
  input  logic [15:0]         q_payload,
  input  logic [BW-1:0]       q_bucket,
  output logic                q_take,
  output logic                ready,
  output logic                res_valid,
  output logic [1:0]          res_status,
  output logic [15:0]         res_payload,
  output logic                res_last
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_READ, S_READW, S_EVAL, S_FLUSH
  } state_t;
  typedef struct packed {
    logic          ok;
    logic [EW-1:0] idx;
  } link_t;

  state_t state_r;
  logic [BW-1:0] clr_r;
  link_t head_mem [MAX_BUCKETS];
  logic [KEY_BITS-1:0] key_mem [POOL_ENTRIES];
  logic [15:0] pay_mem [POOL_ENTRIES];
  link_t next_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] used_r;

  logic [1:0] act_r;
  logic [KEY_BITS-1:0] key_r;
  logic [BW-1:0] bkt_r;
  link_t head_rd_r, cur_r, prev_r;
  logic [KEY_BITS-1:0] ek_rd_r;
  logic [15:0] ep_rd_r;
  link_t en_rd_r;
  logic [EW:0] steps_r;
  logic [EW-1:0] slot_r;
  logic hold_v_r; // pending lookup match waits for last flag
  logic [15:0] hold_p_r;
  logic rv_r, rl_r; logic [1:0] rs_r; logic [15:0] rp_r;

  logic free_ok; logic [EW-1:0] free_idx;
  always_comb begin
    free_ok = 1'b0; free_idx = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin free_ok = 1'b1; free_idx = EW'(i); end
    end
  end

  assign q_take = (state_r == S_IDLE) && q_valid;
  assign ready = state_r == S_IDLE;
  assign res_valid = rv_r; assign res_status = rs_r;
  assign res_payload = rp_r; assign res_last = rl_r;

  // memory ports
  always_ff @(posedge clk) begin
    head_rd_r <= head_mem[bkt_r];
    ek_rd_r <= key_mem[cur_r.idx];
    ep_rd_r <= pay_mem[cur_r.idx];
    en_rd_r <= next_mem[cur_r.idx];
    if (state_r == S_CLEAR) head_mem[clr_r] <= '0;
    else if (state_r == S_HEADW && act_r == ACT_INSERT && !head_rd_r.ok)
      head_mem[bkt_r] <= '{1'b1, slot_r};
    else if (state_r == S_EVAL && act_r == ACT_DELETE && ek_rd_r == key_r &&
             !prev_r.ok)
      head_mem[bkt_r] <= en_rd_r;
    if (state_r == S_IDLE && q_valid && q_action == ACT_INSERT && free_ok) begin
      key_mem[free_idx] <= q_key; pay_mem[free_idx] <= q_payload;
    end
    if (state_r == S_IDLE && q_valid && q_action == ACT_INSERT && free_ok)
      next_mem[free_idx] <= '0;
    else if (state_r == S_EVAL && act_r == ACT_INSERT && (!en_rd_r.ok ||
             32'(steps_r) >= POOL_ENTRIES - 1))
      next_mem[cur_r.idx] <= '{1'b1, slot_r};
    else if (state_r == S_EVAL && act_r == ACT_DELETE && ek_rd_r == key_r &&
             prev_r.ok)
      next_mem[prev_r.idx] <= en_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; used_r <= '0; rv_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      rv_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_BUCKETS - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          act_r <= q_action; key_r <= q_key;
          bkt_r <= q_bucket; slot_r <= free_idx; steps_r <= '0;
          prev_r <= '0; hold_v_r <= 1'b0;
          if (q_action == ACT_INSERT && !free_ok) begin
            rv_r <= 1'b1; rs_r <= ST_FULL; rp_r <= '0; rl_r <= 1'b1;
          end else if (q_action == ACT_INSERT || q_action == ACT_LOOKUP ||
                       q_action == ACT_DELETE) begin
            if (q_action == ACT_INSERT) used_r[free_idx] <= 1'b1;
            state_r <= S_HEAD;
          end else begin
            rv_r <= 1'b1; rs_r <= ST_NOTFOUND; rp_r <= '0; rl_r <= 1'b1;
          end
        end
        S_HEAD: state_r <= S_HEADW;
        S_HEADW: begin
          cur_r <= head_rd_r;
          if (!head_rd_r.ok) begin
            if (act_r == ACT_INSERT) begin
              rv_r <= 1'b1; rs_r <= ST_DONE; rp_r <= '0; rl_r <= 1'b1;
              state_r <= S_IDLE;
            end else state_r <= S_FLUSH;
          end else state_r <= S_READ;
        end
        S_READ: state_r <= S_READW;
        S_READW: state_r <= S_EVAL;
        S_EVAL: begin
          steps_r <= steps_r + 1'b1;
          prev_r <= cur_r; cur_r <= en_rd_r;
          state_r <= S_READ;
          if (act_r == ACT_INSERT) begin
            if (!en_rd_r.ok || 32'(steps_r) >= POOL_ENTRIES - 1) begin
              rv_r <= 1'b1; rs_r <= ST_DONE; rp_r <= '0; rl_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            if (ek_rd_r == key_r) begin
              if (act_r == ACT_DELETE) begin
                used_r[cur_r.idx] <= 1'b0;
                rv_r <= 1'b1; rs_r <= ST_DONE; rp_r <= ep_rd_r; rl_r <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                if (hold_v_r) begin
                  rv_r <= 1'b1; rs_r <= ST_DONE; rp_r <= hold_p_r; rl_r <= 1'b0;
                end
                hold_v_r <= 1'b1; hold_p_r <= ep_rd_r;
              end
            end
            if (state_r == S_EVAL && !(act_r == ACT_DELETE && ek_rd_r == key_r) &&
                (!en_rd_r.ok || 32'(steps_r) >= POOL_ENTRIES - 1))
              state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          rv_r <= 1'b1; rl_r <= 1'b1;
          if (hold_v_r) begin
            rs_r <= ST_DONE; rp_r <= hold_p_r;
          end else begin
            rs_r <= ST_NOTFOUND; rp_r <= '0;
          end
          hold_v_r <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && rl_r |=> !rv_r) else $error("back-to-back last results");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !rv_r && !q_take) else $error("activity during clear");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && rs_r == ST_FULL |-> rl_r && rp_r == 16'd0) else $error("bad full result");
endmodule

/* verif/cht_checker.sv */
// chained hash table checker: watches request, answer and register ports,
// models the table and compares every answer; depends on cht_pkg
module cht_checker import cht_pkg::*; #(
  parameter int KEY_BITS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_action,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [15:0]         in_payload,
  input  logic                out_valid,
  input  logic [1:0]          out_status,
  input  logic [15:0]         out_found_payload,
  input  logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUCKETS = 128;
  localparam int NENTRIES = 64;
  localparam logic [6:0] NO_LINK = 7'd127;
  localparam logic [0:0] ADDR_BUCKET_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload;
    logic        last;
  } answer_t;

  answer_t             answer_q[$];
  logic [7:0]          modulus;
  logic [6:0]          head[NBUCKETS];
  logic [KEY_BITS-1:0] ekey[NENTRIES];
  logic [15:0]         epay[NENTRIES];
  logic [6:0]          enext[NENTRIES];
  logic [NENTRIES-1:0] used;

  assign pending = answer_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int bucket_of(input logic [KEY_BITS-1:0] k);
    int m;
    m = modulus;
    if (m == 0) m = 1;
    if (m > NBUCKETS) m = NBUCKETS;
    return int'(k % m);
  endfunction

  // apply one request to the table model and queue its answers
  task automatic apply_request(input logic [1:0] act, input logic [KEY_BITS-1:0] k,
                               input logic [15:0] p);
    int b, slot, steps, n;
    logic [6:0] cur, prv;
    b = bucket_of(k);
    n = 0;
    slot = -1;
    case (act)
      ACT_INSERT: begin
        for (int i = 0; i < NENTRIES; i++)
          if (!used[i] && slot < 0) slot = i;
        if (slot < 0) begin
          answer_q.push_back('{ST_FULL, 16'd0, 1'b1});
        end else begin
          ekey[slot] = k;
          epay[slot] = p;
          enext[slot] = NO_LINK;
          used[slot] = 1'b1;
          cur = head[b];
          if (cur >= NENTRIES) begin
            head[b] = 7'(slot);
          end else begin
            steps = 0;
            while (enext[cur] < NENTRIES && steps < NENTRIES) begin
              cur = enext[cur];
              steps++;
            end
            enext[cur] = 7'(slot);
          end
          answer_q.push_back('{ST_DONE, 16'd0, 1'b1});
        end
      end
      ACT_LOOKUP: begin
        cur = head[b];
        steps = 0;
        while (cur < NENTRIES && steps < NENTRIES) begin
          if (ekey[cur] == k) begin
            answer_q.push_back('{ST_DONE, epay[cur], 1'b0});
            n++;
          end
          cur = enext[cur];
          steps++;
        end
        if (n == 0) answer_q.push_back('{ST_NOTFOUND, 16'd0, 1'b1});
        else answer_q[$].last = 1'b1;
      end
      ACT_DELETE: begin
        prv = NO_LINK;
        cur = head[b];
        steps = 0;
        while (cur < NENTRIES && steps < NENTRIES && n == 0) begin
          if (ekey[cur] == k) begin
            if (prv < NENTRIES) enext[prv] = enext[cur];
            else head[b] = enext[cur];
            used[cur] = 1'b0;
            answer_q.push_back('{ST_DONE, epay[cur], 1'b1});
            n = 1;
          end else begin
            prv = cur;
            cur = enext[cur];
            steps++;
          end
        end
        if (n == 0) answer_q.push_back('{ST_NOTFOUND, 16'd0, 1'b1});
      end
      default: answer_q.push_back('{ST_NOTFOUND, 16'd0, 1'b1});
    endcase
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      modulus = BUCKET_COUNT_RESET;
      for (int i = 0; i < NBUCKETS; i++) head[i] = NO_LINK;
      for (int i = 0; i < NENTRIES; i++) begin
        ekey[i] = '0;
        epay[i] = '0;
        enext[i] = '0;
      end
      used = '0;
      answer_q.delete();
    end else begin
      // answers first: a request taken at this edge cannot answer in the same cycle
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          report($sformatf("unexpected answer status=%0d payload=%h last=%0b",
                           out_status, out_found_payload, out_last));
        end else begin
          want = answer_q.pop_front();
          if (out_status !== want.status)
            report($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_found_payload !== want.payload)
            report($sformatf("payload %h, want %h", out_found_payload, want.payload));
          if (out_last !== want.last)
            report($sformatf("last %0b, want %0b", out_last, want.last));
        end
      end
      if (start && !busy) apply_request(in_action, in_key, in_payload);
      if (psel && penable && pwrite && pready && paddr == ADDR_BUCKET_COUNT)
        modulus = pwdata[7:0];
    end
  end
endmodule

/* verif/chained_hash_table_tb.sv */
// chained hash table testbench top: clock, reset, requests and register writes
// depends on cht_pkg, chained_hash_table and cht_checker
module chained_hash_table_tb;
  import cht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_BITS = 40;
  localparam int STALL_LIMIT = 20000;   // cycles with no handshake at all
  localparam int SETTLE = 400;          // worst walk: modulo plus a full chain
  localparam logic [1:0] ACT_BAD = 2'd3;
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_action = ACT_INSERT;
  logic [KEY_BITS-1:0] in_key = '0;
  logic [15:0]         in_payload = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [15:0]         out_found_payload;
  logic                out_last;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0]          paddr = 1'b0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count, pending;
  int                  idle_pct;
  int                  quiet_cycles = 0;
  logic [KEY_BITS-1:0] key_pool[12];

  always #10 clk = ~clk;

  chained_hash_table #(.KEY_BITS(KEY_BITS)) i_dut (.*);

  cht_checker #(.KEY_BITS(KEY_BITS)) i_checker (.*);

  // watchdog: any request or answer resets the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request; an optional idle gap first, then hold start until taken
  task automatic send(input logic [1:0] act, input logic [KEY_BITS-1:0] k,
                      input logic [15:0] p);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_payload <= p;
    // busy is decoded from registers only, so its value at the falling edge holds to the next rise
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // drain, let the block settle, then write bucket_count
  task automatic set_buckets(input logic [7:0] v);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= {24'($urandom_range(32'hFFFFFF)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(9) < 8) return key_pool[$urandom_range(11)];
    return KEY_BITS'({$urandom, $urandom});
  endfunction

  initial begin
    int n_items, ins_pct;
    logic [1:0] act;
    logic [7:0] phase_buckets[4] = '{8'd1, 8'd128, 8'd0, 8'd255};
    int phase_idle[4] = '{0, 61, 0, 8};
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys, shared bucket, duplicates, misses, bad action
    send(ACT_INSERT, '0, 16'h0000);
    send(ACT_INSERT, KEY_MAX, 16'hFFFF);
    send(ACT_INSERT, 40'd100, 16'h1234);
    send(ACT_INSERT, '0, 16'h5555);
    send(ACT_LOOKUP, '0, 16'hFFFF);
    send(ACT_LOOKUP, KEY_MAX, 16'h0);
    send(ACT_LOOKUP, 40'd7, 16'h0);
    send(ACT_DELETE, '0, 16'h0);
    send(ACT_LOOKUP, '0, 16'h0);
    send(ACT_DELETE, 40'd12345, 16'h0);
    send(ACT_BAD, 40'd100, 16'hAAAA);
    send(ACT_LOOKUP, 40'd100, 16'h0);
    send(ACT_DELETE, KEY_MAX, 16'h0);
    send(ACT_LOOKUP, KEY_MAX, 16'h0);

    for (int i = 0; i < 12; i++) key_pool[i] = KEY_BITS'({$urandom, $urandom});
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;

    // random phases; the first one sends mostly inserts into one bucket, one long chain that can fill the pool
    for (int ph = 0; ph < 4; ph++) begin
      set_buckets(phase_buckets[ph]);
      idle_pct = phase_idle[ph];
      n_items = (ph == 0) ? 72 : 20;
      ins_pct = (ph == 0) ? 95 : 45;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(99) < 3) act = ACT_BAD;
        else if ($urandom_range(99) < ins_pct) act = ACT_INSERT;
        else act = $urandom_range(1) ? ACT_LOOKUP : ACT_DELETE;
        send(act, pick_key(), 16'($urandom));
      end
    end
    // back to the reset modulus, a few requests with gaps
    set_buckets(BUCKET_COUNT_RESET);
    idle_pct = 30;
    for (int i = 0; i < 10; i++)
      send($urandom_range(1) ? ACT_LOOKUP : ACT_DELETE, pick_key(), 16'($urandom));
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
